>>> src/camera_trigger_strobe_timer_top_assert.svh
// ----------------------------------------------------------------------------
// camera trigger strobe timer assertion macros
// immediate-consequence and next-cycle checks, clocked, with reset disable
// ----------------------------------------------------------------------------
`ifndef CAMERA_TRIGGER_STROBE_TIMER_TOP_ASSERT_SVH
`define CAMERA_TRIGGER_STROBE_TIMER_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define CTST_ASSERT_IMP(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CTST_ASSERT_NXT(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ctst_pkg.sv
// ----------------------------------------------------------------------------
// ctst_pkg
// shared codes, widths, stream field offsets and controller command types
// ----------------------------------------------------------------------------
package ctst_pkg;

  localparam int CHANNELS_DEFAULT    = 4;
  localparam int SOURCE_BITS_DEFAULT = 4;

  // field widths
  localparam int MODE_W   = 2;
  localparam int CH_W     = 2;
  localparam int TIME_W   = 32;
  localparam int SRC_W    = 4;
  localparam int FLAG_W   = 4;
  localparam int KIND_W   = 2;
  localparam int PLEN_W   = 16;
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 3;

  // input tdata layout
  localparam int IN_CH_LSB   = 0;
  localparam int IN_NOW_LSB  = IN_CH_LSB + CH_W;
  localparam int IN_SRC_LSB  = IN_NOW_LSB + TIME_W;
  localparam int IN_DLY_LSB  = IN_SRC_LSB + SRC_W;
  localparam int IN_ONT_LSB  = IN_DLY_LSB + TIME_W;
  localparam int IN_EN_LSB   = IN_ONT_LSB + TIME_W;
  localparam int IN_DATA_W   = 104;

  // output tdata layout
  localparam int OUT_CH_LSB    = 0;
  localparam int OUT_SRC_LSB   = OUT_CH_LSB + CH_W;
  localparam int OUT_TRIG_LSB  = OUT_SRC_LSB + SRC_W;
  localparam int OUT_LIT_LSB   = OUT_TRIG_LSB + FLAG_W;
  localparam int OUT_LIGHT_LSB = OUT_LIT_LSB + FLAG_W;
  localparam int OUT_DATA_W    = 16;

  // item kinds
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIRE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESET = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_LAMP_ON  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LAMP_OFF = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STATUS   = 2'd2;

  // register indexes (paddr bit 2)
  localparam logic REG_PULSE_MODE   = 1'b0;
  localparam logic REG_PULSE_LENGTH = 1'b1;

  localparam logic [PLEN_W-1:0] PULSE_LENGTH_RESET = 16'd50;

  typedef struct packed {
    logic cap;          // capture the accepted item
    logic fire;         // apply a fire to the captured channel
    logic rel_step;     // trigger release check at scan index
    logic strobe_step;  // strobe on/off check at scan index
    logic clear_all;    // disarm, release all, pulse mode to fixed
    logic off_step;     // reset-item lamp off at scan index
    logic status;       // emit the closing status result
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              ch_ok;
    logic              slot_free;
  } stat_t;

endpackage

>>> src/ctst_ctrl.sv
// ----------------------------------------------------------------------------
// ctst_ctrl
// sequencer: dispatches each item; scans channels one per stall-free cycle
// ----------------------------------------------------------------------------
module ctst_ctrl #(
  parameter int CHANNELS = ctst_pkg::CHANNELS_DEFAULT,
  parameter int IDX_W    = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  ctst_pkg::stat_t    stat,
  output ctst_pkg::cmd_t     cmd,
  output logic [IDX_W-1:0]   idx
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_RELEASE,
    S_STROBE,
    S_CLEAR,
    S_STATUS
  } state_t;

  state_t state;
  logic   idx_last;

  assign idx_last = (idx == IDX_W'(CHANNELS - 1));
  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          idx <= '0;
          if (s_tvalid) begin
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          idx <= '0;
          if (stat.mode == ctst_pkg::MODE_TICK) begin
            state <= S_RELEASE;
          end else if (stat.mode == ctst_pkg::MODE_RESET) begin
            state <= S_CLEAR;
          end else begin
            state <= S_STATUS;
          end
        end
        S_RELEASE: begin
          if (idx_last) begin
            idx   <= '0;
            state <= S_STROBE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_STROBE, S_CLEAR: begin
          if (stat.slot_free) begin
            if (idx_last) begin
              idx   <= '0;
              state <= S_STATUS;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        S_STATUS: begin
          if (stat.slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.cap = s_tvalid;
      end
      S_DISPATCH: begin
        cmd.fire      = (stat.mode == ctst_pkg::MODE_FIRE) && stat.ch_ok;
        cmd.clear_all = (stat.mode == ctst_pkg::MODE_RESET);
      end
      S_RELEASE: begin
        cmd.rel_step = 1'b1;
      end
      S_STROBE: begin
        cmd.strobe_step = stat.slot_free;
      end
      S_CLEAR: begin
        cmd.off_step = stat.slot_free;
      end
      S_STATUS: begin
        cmd.status = stat.slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> src/ctst_dp.sv
// ----------------------------------------------------------------------------
// ctst_dp
// channel state, shared elapsed-time compare unit, config and result register
// ----------------------------------------------------------------------------
module ctst_dp #(
  parameter int CHANNELS    = ctst_pkg::CHANNELS_DEFAULT,
  parameter int SOURCE_BITS = ctst_pkg::SOURCE_BITS_DEFAULT,
  parameter int IDX_W       = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ctst_pkg::cmd_t                      cmd,
  input  logic [IDX_W-1:0]                    idx,
  output ctst_pkg::stat_t                     stat,
  input  logic [ctst_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [ctst_pkg::MODE_W-1:0]         s_tuser,
  input  logic                                cfg_wr,
  input  logic                                cfg_sel,
  input  logic [ctst_pkg::DATA_W-1:0]         cfg_wdata,
  output logic [ctst_pkg::DATA_W-1:0]         cfg_rdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ctst_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic [ctst_pkg::KIND_W-1:0]         m_tuser,
  output logic                                m_tlast
);

  localparam int NB = (CHANNELS < ctst_pkg::FLAG_W) ? CHANNELS : ctst_pkg::FLAG_W;

  // captured item
  logic [ctst_pkg::MODE_W-1:0]  cap_mode;
  logic [ctst_pkg::CH_W-1:0]    cap_ch;
  logic [ctst_pkg::TIME_W-1:0]  cap_now;
  logic [SOURCE_BITS-1:0]       cap_src;
  logic [ctst_pkg::TIME_W-1:0]  cap_dly;
  logic [ctst_pkg::TIME_W-1:0]  cap_ont;
  logic                         cap_en;

  // config
  logic                         pulse_mode;
  logic [ctst_pkg::PLEN_W-1:0]  pulse_length;

  // per-channel state
  logic [CHANNELS-1:0]          trig;
  logic [CHANNELS-1:0]          armed;
  logic [CHANNELS-1:0]          lit;
  logic                         light;
  logic [CHANNELS-1:0]          lit_next;
  logic                         light_next;
  logic [ctst_pkg::TIME_W-1:0]  fire_time [CHANNELS];
  logic [ctst_pkg::TIME_W-1:0]  chan_delay [CHANNELS];
  logic [ctst_pkg::TIME_W-1:0]  chan_on_time [CHANNELS];
  logic [SOURCE_BITS-1:0]       latched_src [CHANNELS];

  // compare unit
  logic [ctst_pkg::TIME_W-1:0]  elapsed;
  logic [ctst_pkg::TIME_W-1:0]  span;
  logic [ctst_pkg::TIME_W-1:0]  rel_len;
  logic                         rel_hit;
  logic                         on_ev;
  logic                         off_ev;
  logic                         src_match;
  logic                         emit;
  logic [IDX_W-1:0]             fire_idx;

  // result register
  logic                         o_valid;
  logic [ctst_pkg::KIND_W-1:0]  o_kind;
  logic [ctst_pkg::CH_W-1:0]    o_ch;
  logic [ctst_pkg::SRC_W-1:0]   o_src;
  logic [ctst_pkg::FLAG_W-1:0]  o_trig;
  logic [ctst_pkg::FLAG_W-1:0]  o_lit;
  logic                         o_light;
  logic                         o_last;

  assign fire_idx = IDX_W'(cap_ch);

  assign elapsed   = cap_now - fire_time[idx];
  assign span      = chan_delay[idx] + chan_on_time[idx];
  assign rel_len   = pulse_mode ? span : ctst_pkg::TIME_W'(pulse_length);
  assign rel_hit   = !trig[idx] && (elapsed >= rel_len);
  assign src_match = (cap_src == latched_src[idx]);

  // one strobe step per channel per tick: on, or off
  assign on_ev  = cmd.strobe_step && armed[idx] && !lit[idx] && (elapsed >= chan_delay[idx]);
  assign off_ev = (cmd.strobe_step && armed[idx] && lit[idx] && (elapsed >= span)) ||
                  (cmd.off_step && lit[idx]);

  assign emit = on_ev || off_ev || cmd.status;

  always_comb begin
    lit_next   = lit;
    light_next = light;
    if (on_ev) begin
      lit_next[idx] = 1'b1;
      light_next    = 1'b1;
    end else if (off_ev) begin
      lit_next[idx] = 1'b0;
      if (src_match) begin
        light_next = 1'b0;
      end
    end
  end

  assign stat.mode      = cap_mode;
  assign stat.ch_ok     = (32'(cap_ch) < CHANNELS);
  assign stat.slot_free = !o_valid || m_tready;

  assign cfg_rdata = (cfg_sel == ctst_pkg::REG_PULSE_LENGTH) ?
                     ctst_pkg::DATA_W'(pulse_length) : ctst_pkg::DATA_W'(pulse_mode);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      trig         <= '1;
      armed        <= '0;
      lit          <= '0;
      light        <= 1'b0;
      pulse_mode   <= 1'b0;
      pulse_length <= ctst_pkg::PULSE_LENGTH_RESET;
      o_valid      <= 1'b0;
    end else begin
      lit   <= lit_next;
      light <= light_next;
      if (cmd.fire) begin
        trig[fire_idx]  <= 1'b0;
        armed[fire_idx] <= cap_en;
      end
      if (cmd.rel_step && rel_hit) begin
        trig[idx] <= 1'b1;
      end
      if (cmd.strobe_step && off_ev) begin
        armed[idx] <= 1'b0;
      end
      if (cmd.clear_all) begin
        armed      <= '0;
        trig       <= '1;
        pulse_mode <= 1'b0;
      end
      if (cfg_wr) begin
        if (cfg_sel == ctst_pkg::REG_PULSE_MODE) begin
          pulse_mode <= cfg_wdata[0];
        end else begin
          pulse_length <= cfg_wdata[ctst_pkg::PLEN_W-1:0];
        end
      end
      if (emit) begin
        o_valid <= 1'b1;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cap_mode <= s_tuser;
      cap_ch   <= s_tdata[ctst_pkg::IN_CH_LSB +: ctst_pkg::CH_W];
      cap_now  <= s_tdata[ctst_pkg::IN_NOW_LSB +: ctst_pkg::TIME_W];
      cap_src  <= SOURCE_BITS'(s_tdata[ctst_pkg::IN_SRC_LSB +: ctst_pkg::SRC_W]);
      cap_dly  <= s_tdata[ctst_pkg::IN_DLY_LSB +: ctst_pkg::TIME_W];
      cap_ont  <= s_tdata[ctst_pkg::IN_ONT_LSB +: ctst_pkg::TIME_W];
      cap_en   <= s_tdata[ctst_pkg::IN_EN_LSB];
    end
    if (cmd.fire) begin
      fire_time[fire_idx]    <= cap_now;
      chan_delay[fire_idx]   <= cap_dly;
      chan_on_time[fire_idx] <= cap_ont;
    end
    if (on_ev) begin
      latched_src[idx] <= cap_src;
    end
    if (emit) begin
      o_trig  <= ctst_pkg::FLAG_W'(trig[NB-1:0]);
      o_lit   <= ctst_pkg::FLAG_W'(lit_next[NB-1:0]);
      o_light <= light_next;
      if (cmd.status) begin
        o_kind <= ctst_pkg::KIND_STATUS;
        o_ch   <= '0;
        o_src  <= '0;
        o_last <= 1'b1;
      end else begin
        o_kind <= on_ev ? ctst_pkg::KIND_LAMP_ON : ctst_pkg::KIND_LAMP_OFF;
        o_ch   <= ctst_pkg::CH_W'(idx);
        o_src  <= on_ev ? ctst_pkg::SRC_W'(cap_src) : ctst_pkg::SRC_W'(latched_src[idx]);
        o_last <= 1'b0;
      end
    end
  end

  assign m_tvalid = o_valid;
  assign m_tuser  = o_kind;
  assign m_tlast  = o_last;
  assign m_tdata  = {1'b0, o_light, o_lit, o_trig, o_src, o_ch};

endmodule

>>> src/camera_trigger_strobe_timer_top.sv
// ----------------------------------------------------------------------------
// camera_trigger_strobe_timer_top
// per-channel camera trigger and light strobe timer
// ----------------------------------------------------------------------------
// Items arrive on the s_ stream with mode in s_tuser: a fire item drives one
// channel's trigger low and stores its fire time, delay and on-time; a tick
// item carries the current microsecond time and produces lamp on/off commands
// followed by a status result; a reset item disarms all channels, releases all
// triggers, sets pulse_mode to fixed and turns off every lit lamp. Each item
// ends with a status result marked by m_tlast. One item is handled at a time.
// A single elapsed-time subtract and compare unit visits the channels one per
// cycle, first for trigger release and then for the strobe steps; the strobe
// and reset scans pause while the result stream stalls. The next item is taken
// while the last result still waits in the output register. Registers:
// pulse_mode at 0x0, pulse_length_us at 0x4, to be written only while no item
// is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
`include "camera_trigger_strobe_timer_top_assert.svh"

module camera_trigger_strobe_timer_top #(
  parameter int CHANNELS    = ctst_pkg::CHANNELS_DEFAULT,
  parameter int SOURCE_BITS = ctst_pkg::SOURCE_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // channel[1:0] now_us[33:2] light_source[37:34] delay_us[69:38]
  // on_time_us[101:70] strobe_enable[102]
  input  logic [ctst_pkg::IN_DATA_W-1:0]     s_tdata,
  // mode[1:0]
  input  logic [ctst_pkg::MODE_W-1:0]        s_tuser,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // event_channel[1:0] lamp_id[5:2] trigger_levels[9:6] strobe_lit[13:10]
  // light_is_on[14]
  output logic [ctst_pkg::OUT_DATA_W-1:0]    m_tdata,
  // kind[1:0]
  output logic [ctst_pkg::KIND_W-1:0]        m_tuser,
  output logic                               m_tlast,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ctst_pkg::PADDR_W-1:0]       paddr,
  input  logic [ctst_pkg::DATA_W-1:0]        pwdata,
  output logic [ctst_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  ctst_pkg::cmd_t  cmd;
  ctst_pkg::stat_t stat;
  logic [IDX_W-1:0] idx;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  ctst_ctrl #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd),
    .idx      (idx)
  );

  ctst_dp #(
    .CHANNELS    (CHANNELS),
    .SOURCE_BITS (SOURCE_BITS),
    .IDX_W       (IDX_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .idx       (idx),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_wr    (cfg_wr),
    .cfg_sel   (paddr[2]),
    .cfg_wdata (pwdata),
    .cfg_rdata (prdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // a result is only produced when the output register is free
  `CTST_ASSERT_IMP(a_no_overwrite, clk, rst,
    (cmd.strobe_step || cmd.off_step || cmd.status) && m_tvalid, m_tready,
    "result produced while output register still full")

  // one item at a time
  `CTST_ASSERT_NXT(a_one_item, clk, rst, s_tvalid && s_tready, !s_tready,
    "new item taken while the previous one is in flight")

  // status result closes every item
  `CTST_ASSERT_NXT(a_status_last, clk, rst, cmd.status,
    m_tvalid && m_tlast && (m_tuser == ctst_pkg::KIND_STATUS),
    "status command did not present a final status result")

endmodule

>>> tb/camera_trigger_strobe_timer_top_test.sv
// ----------------------------------------------------------------------------
// camera_trigger_strobe_timer_top_test
// drives fire, tick, reset and unused-mode items and checks every lamp and
// status result against an in-bench model of the channel timers, across
// several register settings and with random stalls on both streams
// ----------------------------------------------------------------------------
module camera_trigger_strobe_timer_top_test;
  import ctst_pkg::*;

  localparam int NCH = CHANNELS_DEFAULT;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 10000;
  localparam int PHASE_ITEMS = 60;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CH_W-1:0]   ch;
    logic [31:0]       now;
    logic [3:0]        src;
    logic [31:0]       dly;
    logic [31:0]       ont;
    logic              en;
  } stim_t;

  typedef struct packed {
    stim_t      s;
    logic       typed;
    logic [3:0] trig;
    logic [3:0] lit;
    logic       light;
  } row_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CH_W-1:0]   ch;
    logic [3:0]        src;
    logic [3:0]        trig;
    logic [3:0]        lit;
    logic              light;
    logic              last;
  } lamp_ev_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic [IN_DATA_W-1:0]    s_tdata = '0;
  logic [MODE_W-1:0]       s_tuser = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [OUT_DATA_W-1:0]   m_tdata;
  logic [KIND_W-1:0]       m_tuser;
  logic                    m_tlast;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [PADDR_W-1:0]      paddr = '0;
  logic [DATA_W-1:0]       pwdata = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  camera_trigger_strobe_timer_top dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast), .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // timer model state
  logic [NCH-1:0] trig_lvl = '1;
  logic [NCH-1:0] armed = '0;
  logic [NCH-1:0] lit = '0;
  logic [3:0]     latched [NCH];
  logic [31:0]    dly_r [NCH];
  logic [31:0]    ont_r [NCH];
  logic [31:0]    fired_at [NCH];
  logic           light = 1'b0;
  logic           p_mode = 1'b0;
  logic [15:0]    p_len = PULSE_LENGTH_RESET;

  lamp_ev_t    due_events [$];
  row_t        directed_rows [$];
  int unsigned mismatches = 0;
  int unsigned snd_idle = 0;
  int unsigned rcv_idle = 0;
  int unsigned quiet = 0;
  logic [31:0] clock_us = '0;
  logic [3:0]  cur_src = '0;
  lamp_ev_t    want;

  initial begin
    for (int i = 0; i < NCH; i++) begin
      latched[i] = '0;
      dly_r[i] = '0;
      ont_r[i] = '0;
      fired_at[i] = '0;
    end
  end

  function automatic void queue_event(logic [KIND_W-1:0] k, logic [CH_W-1:0] c,
                                      logic [3:0] s, logic l);
    lamp_ev_t ev;
    ev.kind = k;
    ev.ch = c;
    ev.src = s;
    ev.trig = trig_lvl;
    ev.lit = lit;
    ev.light = light;
    ev.last = l;
    due_events.push_back(ev);
  endfunction

  task automatic predict_lamp_events(input stim_t it);
    logic [31:0] elapsed;
    logic [31:0] span;
    case (it.mode)
      MODE_TICK: begin
        // trigger releases first, then one strobe step per channel
        for (int i = 0; i < NCH; i++) begin
          if (!trig_lvl[i]) begin
            elapsed = it.now - fired_at[i];
            span = p_mode ? dly_r[i] + ont_r[i] : {16'd0, p_len};
            if (elapsed >= span) trig_lvl[i] = 1'b1;
          end
        end
        for (int i = 0; i < NCH; i++) begin
          if (armed[i]) begin
            elapsed = it.now - fired_at[i];
            span = dly_r[i] + ont_r[i];
            if (!lit[i] && elapsed >= dly_r[i]) begin
              latched[i] = it.src;
              light = 1'b1;
              lit[i] = 1'b1;
              queue_event(KIND_LAMP_ON, CH_W'(i), latched[i], 1'b0);
            end else if (lit[i] && elapsed >= span) begin
              lit[i] = 1'b0;
              if (it.src == latched[i]) light = 1'b0;
              armed[i] = 1'b0;
              queue_event(KIND_LAMP_OFF, CH_W'(i), latched[i], 1'b0);
            end
          end
        end
      end
      MODE_FIRE: begin
        if (int'(it.ch) < NCH) begin
          trig_lvl[it.ch] = 1'b0;
          fired_at[it.ch] = it.now;
          dly_r[it.ch] = it.dly;
          ont_r[it.ch] = it.ont;
          armed[it.ch] = it.en;
        end
      end
      MODE_RESET: begin
        armed = '0;
        trig_lvl = '1;
        p_mode = 1'b0;
        for (int i = 0; i < NCH; i++) begin
          if (lit[i]) begin
            lit[i] = 1'b0;
            if (it.src == latched[i]) light = 1'b0;
            queue_event(KIND_LAMP_OFF, CH_W'(i), latched[i], 1'b0);
          end
        end
      end
      default: ;
    endcase
    queue_event(KIND_STATUS, '0, '0, 1'b1);
  endtask

  // result checking
  function automatic void check_field(string name, logic [3:0] exp_v, logic [3:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s expected %0h got %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (due_events.size() == 0) begin
        $display("%0t unexpected result kind %0h data %0h", $time, m_tuser, m_tdata);
        mismatches++;
      end else begin
        want = due_events.pop_front();
        check_field("kind", 4'(want.kind), 4'(m_tuser));
        check_field("event_channel", 4'(want.ch), 4'(m_tdata[OUT_SRC_LSB-1:OUT_CH_LSB]));
        check_field("lamp_id", want.src, m_tdata[OUT_TRIG_LSB-1:OUT_SRC_LSB]);
        check_field("trigger_levels", want.trig, m_tdata[OUT_LIT_LSB-1:OUT_TRIG_LSB]);
        check_field("strobe_lit", want.lit, m_tdata[OUT_LIGHT_LSB-1:OUT_LIT_LSB]);
        check_field("light_is_on", 4'(want.light), 4'(m_tdata[OUT_LIGHT_LSB]));
        check_field("last", 4'(want.last), 4'(m_tlast));
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
        quiet = 0;
      else begin
        quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("[camera_trigger_strobe_timer_top] ERROR");
          $finish;
        end
      end
    end
  end

  // register access: a setup phase, then an access phase held until pready
  task automatic apb_xfer(input logic wr, input logic [PADDR_W-1:0] a,
                          input logic [DATA_W-1:0] d, output logic [DATA_W-1:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
  endtask

  task automatic set_register(input logic idx, input logic [15:0] value);
    logic [DATA_W-1:0] rd;
    logic [DATA_W-1:0] mask;
    mask = (idx == REG_PULSE_MODE) ? 32'h1 : 32'hFFFF;
    apb_xfer(1'b1, {idx, 2'b00}, {16'd0, value}, rd);
    apb_xfer(1'b0, {idx, 2'b00}, '0, rd);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_PULSE_MODE) p_mode = value[0];
    else p_len = value;
    if ((rd & mask) !== ({16'd0, value} & mask)) begin
      $display("%0t mismatch register %0d expected %0h got %0h", $time, idx,
               {16'd0, value} & mask, rd & mask);
      mismatches++;
    end
  endtask

  task automatic send_item(input stim_t it);
    s_tdata <= {1'b0, it.en, it.ont, it.dly, it.src, it.now, it.ch};
    s_tuser <= it.mode;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_lamp_events(it);
  endtask

  task automatic sender_gap();
    if ($urandom_range(99) < snd_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
  endtask

  // hold off until every result is back, then let the block settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic stim_t mk(logic [MODE_W-1:0] mode, logic [CH_W-1:0] ch,
                               logic [31:0] now, logic [3:0] src, logic [31:0] dly,
                               logic [31:0] ont, logic en);
    stim_t it;
    it.mode = mode;
    it.ch = ch;
    it.now = now;
    it.src = src;
    it.dly = dly;
    it.ont = ont;
    it.en = en;
    return it;
  endfunction

  function automatic void dir_row(stim_t it);
    row_t r;
    r = '0;
    r.s = it;
    directed_rows.push_back(r);
  endfunction

  function automatic void dir_row_chk(stim_t it, logic [3:0] trig, logic [3:0] lt, logic lo);
    row_t r;
    r.s = it;
    r.typed = 1'b1;
    r.trig = trig;
    r.lit = lt;
    r.light = lo;
    directed_rows.push_back(r);
  endfunction

  function automatic logic [31:0] draw_span();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 32'd0;
    if (r == 1) return $urandom;
    return $urandom_range(60);
  endfunction

  task automatic draw_item(output stim_t it);
    int unsigned pick;
    pick = $urandom_range(99);
    it = stim_t'({$urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(19) == 0) cur_src = 4'($urandom_range(15));
    it.src = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : cur_src;
    if (pick < 45) begin
      // time mostly creeps forward, now and then it jumps anywhere
      clock_us = clock_us + (($urandom_range(19) == 0) ? $urandom : $urandom_range(40));
      it.mode = MODE_TICK;
      it.now = clock_us;
    end else if (pick < 80) begin
      it.mode = MODE_FIRE;
      it.now = clock_us;
      it.dly = draw_span();
      it.ont = draw_span();
      it.en = ($urandom_range(3) != 0);
    end else if (pick < 88) begin
      it.mode = MODE_RESET;
    end else if (pick < 92) begin
      it.mode = MODE_UNUSED;
    end else begin
      it.mode = MODE_W'($urandom_range(3));
    end
  endtask

  initial begin
    stim_t       it;
    lamp_ev_t    ev;
    int unsigned phase_mode [6];
    int unsigned phase_len [6];
    int unsigned plen;

    phase_mode = '{1, 0, 0, 1, 0, 1};
    phase_len = '{0, 1, 65535, 65535, 0, 0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    snd_idle = 14;
    rcv_idle = 67;

    // defaults after reset: fixed pulse of 50 us
    dir_row_chk(mk(MODE_TICK, 2'd0, 32'd0, 4'h0, 32'd0, 32'd0, 1'b0), 4'hF, 4'h0, 1'b0);
    dir_row_chk(mk(MODE_UNUSED, 2'd3, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   1'b1), 4'hF, 4'h0, 1'b0);
    dir_row_chk(mk(MODE_FIRE, 2'd0, 32'd1000, 4'h0, 32'd10, 32'd20, 1'b1), 4'hE, 4'h0, 1'b0);
    dir_row_chk(mk(MODE_FIRE, 2'd3, 32'd1000, 4'h0, 32'd0, 32'd0, 1'b1), 4'h6, 4'h0, 1'b0);
    dir_row(mk(MODE_TICK, 2'd0, 32'd1000, 4'h5, 32'd0, 32'd0, 1'b0));
    // lamp off with a different source selected keeps the light on
    dir_row(mk(MODE_TICK, 2'd0, 32'd1010, 4'h7, 32'd0, 32'd0, 1'b0));
    dir_row(mk(MODE_TICK, 2'd0, 32'd1030, 4'h7, 32'd0, 32'd0, 1'b0));
    dir_row(mk(MODE_TICK, 2'd0, 32'd1050, 4'h0, 32'd0, 32'd0, 1'b0));
    // elapsed time across the 32-bit wrap, maximum delay and on-time
    dir_row(mk(MODE_FIRE, 2'd1, 32'hFFFF_FFF0, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    dir_row(mk(MODE_TICK, 2'd0, 32'h0000_0010, 4'hF, 32'd0, 32'd0, 1'b0));
    dir_row(mk(MODE_TICK, 2'd0, 32'h0000_0030, 4'hF, 32'd0, 32'd0, 1'b0));
    // refire while lit, not armed: stays lit until a reset item
    dir_row(mk(MODE_FIRE, 2'd2, 32'd100, 4'h3, 32'd5, 32'd100, 1'b1));
    dir_row(mk(MODE_TICK, 2'd0, 32'd105, 4'h3, 32'd0, 32'd0, 1'b0));
    dir_row(mk(MODE_FIRE, 2'd2, 32'd110, 4'h3, 32'd0, 32'd0, 1'b0));
    dir_row(mk(MODE_TICK, 2'd0, 32'd400, 4'h3, 32'd0, 32'd0, 1'b0));
    dir_row(mk(MODE_FIRE, 2'd0, 32'd400, 4'h9, 32'd0, 32'd0, 1'b1));
    dir_row(mk(MODE_TICK, 2'd0, 32'd400, 4'h9, 32'd0, 32'd0, 1'b0));
    dir_row(mk(MODE_RESET, 2'd0, 32'd401, 4'h9, 32'd0, 32'd0, 1'b0));
    // refire while lit and armed: off at the new delay plus on-time
    dir_row(mk(MODE_FIRE, 2'd1, 32'd500, 4'h4, 32'd2, 32'd3, 1'b1));
    dir_row(mk(MODE_TICK, 2'd0, 32'd502, 4'h4, 32'd0, 32'd0, 1'b0));
    dir_row(mk(MODE_FIRE, 2'd1, 32'd503, 4'h4, 32'd10, 32'd10, 1'b1));
    dir_row(mk(MODE_TICK, 2'd0, 32'd513, 4'h4, 32'd0, 32'd0, 1'b0));
    dir_row(mk(MODE_TICK, 2'd0, 32'd523, 4'h6, 32'd0, 32'd0, 1'b0));
    dir_row(mk(MODE_RESET, 2'd3, 32'd524, 4'h0, 32'hFFFF_FFFF, 32'd0, 1'b1));
    dir_row(mk(MODE_TICK, 2'd0, 32'hFFFF_FFFF, 4'h0, 32'd0, 32'd0, 1'b0));

    foreach (directed_rows[k]) begin
      send_item(directed_rows[k].s);
      if (directed_rows[k].typed) begin
        ev = due_events.pop_back();
        ev.trig = directed_rows[k].trig;
        ev.lit = directed_rows[k].lit;
        ev.light = directed_rows[k].light;
        due_events.push_back(ev);
      end
      sender_gap();
    end

    clock_us = $urandom;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        snd_idle = 67;
        rcv_idle = 14;
      end else if (ph == 4) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      drain_results();
      plen = (ph >= 4) ? $urandom_range(phase_mode[ph] ? 65535 : 120) : phase_len[ph];
      set_register(REG_PULSE_LENGTH, 16'(plen));
      set_register(REG_PULSE_MODE, 16'(phase_mode[ph]));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        draw_item(it);
        send_item(it);
        if ($urandom_range(29) == 0) drain_results();
        else sender_gap();
      end
    end

    s_tvalid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (2 * NCH + 16) @(posedge clk);
    if (mismatches == 0) begin
      $display("[camera_trigger_strobe_timer_top] OK");
    end else begin
      $display("[camera_trigger_strobe_timer_top] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/ctst_pkg.sv
src/ctst_ctrl.sv
src/ctst_dp.sv
src/camera_trigger_strobe_timer_top.sv
tb/camera_trigger_strobe_timer_top_test.sv
